// File: sv/swld_pkg.sv
`default_nettype none

package swld_pkg;

	localparam int HDR_LEN       = 6;
	localparam int MAX_RESULTS   = 6;
	localparam int MAX_FRAME_DEF = 1024;
	localparam int QUEUE_DEPTH   = 16;
	localparam int TOT_W         = 17;
	localparam int BURST_CNT_W   = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0]  SYNC_FIRST_RST  = 8'd161;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'd26;
	localparam logic [10:0] MAX_BYTES_RST   = 11'd1024;

	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] CFG_MAX_BYTES   = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       last;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic [BURST_CNT_W-1:0]       count;
		result_t [MAX_RESULTS-1:0] ent;
	} burst_t;

endpackage

`default_nettype wire

// File: sv/sync_word_length_deframer_unit.sv
// Channel   Direction  Handshake             Payload
// in        receive    in_valid / in_stall   in_byte
// out       send       out_valid / out_stall out_byte, frame_start, frame_end, run_end
// cfg       receive    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One input byte is taken every cycle if in_stall is low; the parser updates its state in
// the same cycle. The six-beat header run of a frame is written at once into a
// sixteen-entry result queue, which sends one beat per cycle if out_stall is low; in_stall
// rises while fewer than six entries are free. The block is ready straight after reset,
// with no clearing pass. Configuration writes are always taken; cfg_ready is held high.
`default_nettype none

module sync_word_length_deframer_unit #(
	parameter int MAX_FRAME = swld_pkg::MAX_FRAME_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             frame_start,
	output logic             frame_end,
	output logic             run_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);
	import swld_pkg::*;

	burst_t  burst;
	result_t head;
	logic    almost_full;
	logic    accept;

	assign in_stall  = almost_full;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	swld_parser #(
		.MAX_FRAME(MAX_FRAME)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.burst    (burst)
	);

	swld_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst      (burst),
		.almost_full(almost_full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.head       (head)
	);

	assign out_byte    = head.data;
	assign frame_start = head.start;
	assign frame_end   = head.last;
	assign run_end     = head.run_last;

endmodule

`default_nettype wire

// File: sv/swld_parser.sv
`default_nettype none

module swld_parser #(
	parameter int MAX_FRAME = swld_pkg::MAX_FRAME_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      in_byte,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [10:0]     cfg_data,
	output swld_pkg::burst_t     burst
);
	import swld_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME - HDR_LEN + 1);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [7:0]       sync_first_q;
	logic [7:0]       sync_second_q;
	logic [10:0]      max_bytes_q;
	logic [1:0]       phase_q, phase_d;
	logic             saw_q, saw_d;
	logic [2:0]       hidx_q, hidx_d;
	logic [CNT_W-1:0] left_q, left_d;
	logic [7:0]       len_lo_q;
	logic             len_lo_we;
	logic [7:0]       hold_q [4];
	logic             hold_we;
	logic [1:0]       hold_sel;

	logic [15:0]      plen;
	logic [TOT_W-1:0] total;
	logic [TOT_W-1:0] limit;
	logic [CNT_W-1:0] left_dec;

	assign plen  = {in_byte, len_lo_q};
	assign total = TOT_W'(plen) + TOT_W'(HDR_LEN);
	assign limit = (TOT_W'(max_bytes_q) < TOT_W'(MAX_FRAME)) ? TOT_W'(max_bytes_q)
	                                                          : TOT_W'(MAX_FRAME);
	assign left_dec = (left_q != '0) ? left_q - CNT_W'(1) : left_q;

	always_comb begin
		phase_d   = phase_q;
		saw_d     = saw_q;
		hidx_d    = hidx_q;
		left_d    = left_q;
		len_lo_we = 1'b0;
		hold_we   = 1'b0;
		hold_sel  = 2'd0;
		burst     = '0;
		unique case (phase_q)
			PH_HEADER: begin
				case (hidx_q) inside
					3'd2, 3'd3: begin
						hold_we  = 1'b1;
						hold_sel = hidx_q[1:0];
						hidx_d   = hidx_q + 3'd1;
					end
					3'd4: begin
						len_lo_we = 1'b1;
						hidx_d    = 3'd5;
					end
					default: begin
						hidx_d = 3'd0;
						saw_d  = 1'b0;
						if (total > limit) begin
							phase_d = PH_HUNT;
							left_d  = '0;
						end else begin
							burst.count = BURST_CNT_W'(MAX_RESULTS);
							burst.ent[0] = '{data: hold_q[0], start: 1'b1, last: 1'b0,
								run_last: 1'b0};
							burst.ent[1] = '{data: hold_q[1], start: 1'b0, last: 1'b0,
								run_last: 1'b0};
							burst.ent[2] = '{data: hold_q[2], start: 1'b0, last: 1'b0,
								run_last: 1'b0};
							burst.ent[3] = '{data: hold_q[3], start: 1'b0, last: 1'b0,
								run_last: 1'b0};
							burst.ent[4] = '{data: len_lo_q, start: 1'b0, last: 1'b0,
								run_last: 1'b0};
							burst.ent[5] = '{data: in_byte, start: 1'b0, last: plen == '0,
								run_last: 1'b1};
							left_d  = CNT_W'(plen);
							phase_d = (plen == '0) ? PH_HUNT : PH_PAYLOAD;
						end
					end
				endcase
			end
			PH_PAYLOAD: begin
				left_d       = left_dec;
				burst.count  = BURST_CNT_W'(1);
				burst.ent[0] = '{data: in_byte, start: 1'b0, last: left_dec == '0,
					run_last: 1'b1};
				if (left_dec == '0) begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (saw_q && in_byte == sync_second_q) begin
					hold_we  = 1'b1;
					hold_sel = 2'd1;
					saw_d    = 1'b0;
					hidx_d   = 3'd2;
					phase_d  = PH_HEADER;
				end else if (in_byte == sync_first_q) begin
					hold_we  = 1'b1;
					hold_sel = 2'd0;
					saw_d    = 1'b1;
				end else begin
					saw_d = 1'b0;
				end
			end
		endcase
		if (!accept) begin
			burst.count = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			max_bytes_q   <= MAX_BYTES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_data[7:0];
				CFG_SYNC_SECOND: sync_second_q <= cfg_data[7:0];
				CFG_MAX_BYTES:   max_bytes_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			saw_q   <= 1'b0;
			hidx_q  <= 3'd0;
			left_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			saw_q   <= saw_d;
			hidx_q  <= hidx_d;
			left_q  <= left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_we) begin
			hold_q[hold_sel] <= in_byte;
		end
		if (accept && len_lo_we) begin
			len_lo_q <= in_byte;
		end
	end

endmodule

`default_nettype wire

// File: sv/swld_out_queue.sv
`default_nettype none

module swld_out_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire swld_pkg::burst_t  burst,
	output logic                   almost_full,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output swld_pkg::result_t      head
);
	import swld_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	result_t          mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign out_valid   = count_q != '0;
	assign pop         = out_valid && !out_stall;
	assign head        = mem[rd_ptr_q];
	assign almost_full = count_q > CNT_W'(QUEUE_DEPTH - MAX_RESULTS);

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (BURST_CNT_W'(k) < burst.count) begin
				mem[PTR_W'(wr_ptr_q + PTR_W'(k))] <= burst.ent[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(burst.count));
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(burst.count) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// File: dv/sync_word_length_deframer_unit_test.sv
module sync_word_length_deframer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swld_pkg::*;

	localparam logic [1:0] CFG_NONE = 2'd3;

	typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_PAYLOAD} parse_phase_t;
	typedef enum logic [1:0] {FLOW, COIN, EVERY_THIRD, MOSTLY} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        frame_start;
	logic        frame_end;
	logic        run_end;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [10:0] cfg_data = 11'd0;

	sync_word_length_deframer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.frame_start(frame_start),
		.frame_end(frame_end),
		.run_end(run_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow configuration and parser state.
	logic [7:0]   sync1 = SYNC_FIRST_RST;
	logic [7:0]   sync2 = SYNC_SECOND_RST;
	logic [10:0]  max_bytes = MAX_BYTES_RST;
	parse_phase_t pphase = HUNTING;
	logic         saw_first = 1'b0;
	logic [7:0]   hdr_hold [4];
	logic [2:0]   hdr_idx = 3'd0;
	logic [15:0]  pay_left = 16'd0;

	result_t     frame_beats_q [$];
	logic [7:0]  pend_q [$];
	int unsigned err_cnt = 0;
	int unsigned beats_seen = 0;

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	logic        nxt_valid;
	logic [7:0]  nxt_byte;

	stall_mode_t stall_mode = FLOW;
	int unsigned stall_tick = 0;
	logic        stall_pat;
	logic        hold_out = 1'b0;

	function automatic result_t make_beat(input logic [7:0] d, input logic s, input logic e,
			input logic r);
		result_t x;
		x.data = d;
		x.start = s;
		x.last = e;
		x.run_last = r;
		return x;
	endfunction

	function automatic int unsigned frame_limit();
		return (max_bytes < MAX_FRAME_DEF) ? int'(max_bytes) : MAX_FRAME_DEF;
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		int unsigned plen;
		logic is_last;
		if (pphase == IN_HEADER) begin
			if (hdr_idx == 3'd2 || hdr_idx == 3'd3) begin
				hdr_hold[hdr_idx[1:0]] = b;
				hdr_idx = hdr_idx + 3'd1;
			end else if (hdr_idx == 3'd4) begin
				pay_left = {8'd0, b};
				hdr_idx = 3'd5;
			end else begin
				plen = int'({b, pay_left[7:0]});
				hdr_idx = 3'd0;
				saw_first = 1'b0;
				if (plen + HDR_LEN > frame_limit()) begin
					pphase = HUNTING;
					pay_left = 16'd0;
				end else begin
					is_last = (plen == 0);
					frame_beats_q.push_back(make_beat(hdr_hold[0], 1'b1, 1'b0, 1'b0));
					frame_beats_q.push_back(make_beat(hdr_hold[1], 1'b0, 1'b0, 1'b0));
					frame_beats_q.push_back(make_beat(hdr_hold[2], 1'b0, 1'b0, 1'b0));
					frame_beats_q.push_back(make_beat(hdr_hold[3], 1'b0, 1'b0, 1'b0));
					frame_beats_q.push_back(make_beat(pay_left[7:0], 1'b0, 1'b0, 1'b0));
					frame_beats_q.push_back(make_beat(b, 1'b0, is_last, 1'b1));
					pay_left = plen[15:0];
					pphase = is_last ? HUNTING : IN_PAYLOAD;
				end
			end
		end else if (pphase == IN_PAYLOAD) begin
			if (pay_left > 0)
				pay_left = pay_left - 16'd1;
			is_last = (pay_left == 0);
			frame_beats_q.push_back(make_beat(b, 1'b0, is_last, 1'b1));
			if (is_last)
				pphase = HUNTING;
		end else begin
			pphase = HUNTING;
			if (saw_first && b == sync2) begin
				hdr_hold[1] = b;
				saw_first = 1'b0;
				hdr_idx = 3'd2;
				pphase = IN_HEADER;
			end else if (b == sync1) begin
				hdr_hold[0] = b;
				saw_first = 1'b1;
			end else begin
				saw_first = 1'b0;
			end
		end
	endtask

	task automatic log_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s", msg);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				deframe_byte(in_byte);
			if (!in_valid || !in_stall) begin
				nxt_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_q.size() > 0) begin
					nxt_valid = 1'b1;
					nxt_byte = pend_q.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
				in_valid <= nxt_valid;
				if (nxt_valid)
					in_byte <= nxt_byte;
			end
		end
	end

	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick % 50 == 0)
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			FLOW: stall_pat = 1'b0;
			COIN: stall_pat = 1'($urandom_range(0, 1));
			EVERY_THIRD: stall_pat = (stall_tick % 3 == 0);
			default: stall_pat = ($urandom_range(0, 4) != 0);
		endcase
		out_stall <= hold_out | stall_pat;
	end

	// Hold the output off for a long stretch while the sender keeps offering bytes.
	initial begin
		do @(posedge clk); while (!(in_valid && pend_q.size() > 20));
		hold_out <= 1'b1;
		repeat (120) @(posedge clk);
		hold_out <= 1'b0;
	end

	always @(posedge clk) begin
		result_t w;
		if (arst_n && out_valid && !out_stall) begin
			beats_seen++;
			if (frame_beats_q.size() == 0) begin
				log_error($sformatf("beat %0d unexpected: byte %h start %b end %b run_end %b",
					beats_seen, out_byte, frame_start, frame_end, run_end));
			end else begin
				w = frame_beats_q.pop_front();
				if (out_byte !== w.data || frame_start !== w.start || frame_end !== w.last ||
						run_end !== w.run_last)
					log_error($sformatf({"beat %0d mismatch: expected byte %h start %b end %b ",
						"run_end %b, got byte %h start %b end %b run_end %b"}, beats_seen,
						w.data, w.start, w.last, w.run_last,
						out_byte, frame_start, frame_end, run_end));
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SYNC_FIRST: sync1 = val[7:0];
			CFG_SYNC_SECOND: sync2 = val[7:0];
			CFG_MAX_BYTES: max_bytes = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		do @(posedge clk); while (pend_q.size() != 0 || in_valid || frame_beats_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic push_frame(input int unsigned plen);
		pend_q.push_back(sync1);
		pend_q.push_back(sync2);
		pend_q.push_back(8'($urandom));
		pend_q.push_back(8'($urandom));
		pend_q.push_back(plen[7:0]);
		pend_q.push_back(plen[15:8]);
		if (plen + HDR_LEN <= frame_limit())
			repeat (plen) pend_q.push_back(8'($urandom));
	endtask

	task automatic push_random(input int unsigned n);
		int unsigned base;
		int unsigned k;
		int unsigned plen;
		int unsigned lim;
		logic [7:0] b;
		base = pend_q.size();
		lim = frame_limit();
		while (pend_q.size() - base < n) begin
			k = $urandom_range(0, 99);
			if (k < 65) begin
				k = $urandom_range(0, 9);
				if (k < 6)
					plen = $urandom_range(0, 8);
				else if (k < 8)
					plen = $urandom_range(9, 24);
				else if (k == 8)
					plen = (lim >= 6 && lim <= 40) ? lim - 6 : $urandom_range(0, 3);
				else
					plen = (lim >= 6 && lim < 1024) ? lim - 5 : $urandom_range(1019, 65535);
				push_frame(plen);
			end else if (k < 80) begin
				repeat ($urandom_range(1, 4))
					pend_q.push_back(($urandom_range(0, 3) == 0) ? sync1 : 8'($urandom));
			end else begin
				pend_q.push_back(sync1);
				if ($urandom_range(0, 1) == 0) begin
					b = 8'($urandom);
					if (b == sync2)
						b = b + 8'd1;
					pend_q.push_back(b);
				end else begin
					pend_q.push_back(sync2);
					repeat ($urandom_range(1, 3)) pend_q.push_back(8'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: repeated first sync byte with an empty payload, a short frame,
		// an oversize frame and a sync byte that is not followed by the second one.
		pend_q = '{8'd161, 8'd161, 8'd26, 8'h00, 8'hFF, 8'h00, 8'h00,
			8'd161, 8'd26, 8'h80, 8'h7F, 8'h02, 8'h00, 8'hFF, 8'h00,
			8'd161, 8'd26, 8'h11, 8'h22, 8'h01, 8'h04,
			8'd161, 8'h33};
		push_random(40);
		pend_q.push_back(8'd161);
		pend_q.push_back(8'd26);
		pend_q.push_back(8'h3C);
		drain();

		// The header begun above completes under the new settings.
		write_reg(CFG_SYNC_FIRST, 11'h700);
		write_reg(CFG_SYNC_SECOND, 11'h0FF);
		write_reg(CFG_MAX_BYTES, 11'd6);
		pend_q.push_back(8'h5A);
		pend_q.push_back(8'h00);
		pend_q.push_back(8'h00);
		push_random(40);
		drain();

		write_reg(CFG_NONE, 11'h7FF);
		write_reg(CFG_MAX_BYTES, 11'd0);
		push_random(30);
		drain();

		write_reg(CFG_SYNC_FIRST, 11'($urandom_range(0, 255)));
		write_reg(CFG_SYNC_SECOND, 11'($urandom_range(0, 255)));
		write_reg(CFG_MAX_BYTES, 11'h7FF);
		push_frame(1019);
		push_random(35);
		drain();

		write_reg(CFG_SYNC_FIRST, 11'h077);
		write_reg(CFG_SYNC_SECOND, 11'h077);
		write_reg(CFG_MAX_BYTES, 11'(6 + $urandom_range(8, 30)));
		push_random(40);
		drain();

		write_reg(CFG_SYNC_FIRST, 11'(SYNC_FIRST_RST));
		write_reg(CFG_SYNC_SECOND, 11'(SYNC_SECOND_RST));
		write_reg(CFG_MAX_BYTES, 11'd1024);
		push_random(35);
		drain();

		repeat (20) @(posedge clk);
		if (err_cnt == 0 && frame_beats_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
